// File: rtl/core/gbdt_pkg.sv
`default_nettype none
package gbdt_pkg;

	localparam int MaxVertices = 32;
	localparam int MaxEdges    = 256;
	localparam int VtxW        = $clog2(MaxVertices);
	localparam int EdgeW       = $clog2(MaxEdges);
	localparam int LinkW       = EdgeW + 1;
	localparam int CntW        = $clog2(MaxVertices + 1);
	localparam int NumW        = 6;

	localparam logic [LinkW-1:0] NullLink = LinkW'(MaxEdges);

	typedef enum logic [1:0] {
		ACT_ADD  = 2'd0,
		ACT_DFS  = 2'd1,
		ACT_BFS  = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_VISIT = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_ERR,
		S_START,
		S_POP,
		S_POPRD,
		S_HEADRD,
		S_HEAD,
		S_EDGE
	} state_t;

	typedef struct packed {
		logic [1:0]      action;
		logic [VtxW-1:0] first_vertex;
		logic [VtxW-1:0] second_vertex;
	} req_t;

	typedef struct packed {
		logic [VtxW-1:0] vertex;
		logic [1:0]      status;
		logic            last;
	} res_t;

	// work list control from sequencer to work list unit
	typedef struct packed {
		logic            clear;
		logic            push;
		logic [VtxW-1:0] push_vtx;
		logic            pop;
		logic            lifo;
	} wl_ctrl_t;

	typedef struct packed {
		logic            empty;
		logic            full;
		logic [VtxW-1:0] rd_vtx;
	} wl_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/gbdt_if.sv
`default_nettype none
interface gbdt_req_if;
	import gbdt_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gbdt_res_if;
	import gbdt_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gbdt_cfg_if;
	import gbdt_pkg::*;
	logic            valid;
	logic            ready;
	logic [NumW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/graph_bfs_dfs_traversal.sv
`default_nettype none
// Channel | dir | payload
// req     | in  | action, first_vertex, second_vertex
// res     | out | vertex, status, last
// cfg     | in  | num_vertices (6 bits, reset 32)
// Add edge or error: checked in idle, then done. Traversal pushes the start,
// then pops each vertex and walks its edges, one edge memory read each.
// A visit goes out after its list is walked, so its last flag is known.
// arst_n clears lists, edge count and control. A stalled result holds the
// sequencer; a request is taken only in idle.
module graph_bfs_dfs_traversal (
	input wire logic clk,
	input wire logic arst_n,
	gbdt_req_if.sink   req,
	gbdt_res_if.source res,
	gbdt_cfg_if.sink   cfg
);
	import gbdt_pkg::*;

	state_t state_q, state_d;
	logic [NumW-1:0] num_q;
	logic [NumW-1:0] n_act;
	logic [VtxW-1:0] a_q, b_q, cur_q;
	logic            dfs_q;
	status_t         err_q;
	logic            have_q;
	logic [MaxVertices-1:0] vis_q;
	logic [LinkW-1:0] e_q;
	logic [EdgeW:0]   steps_q;
	logic             out_v_q;
	res_t             out_q;
	wl_ctrl_t         wl;
	wl_stat_t         ws;
	logic add, head_rd, edge_rd, full;
	logic [LinkW-1:0] head_q, link_q;
	logic [VtxW-1:0]  tgt_q;
	logic accept;
	logic a_ok, b_ok;
	logic edge_ok;
	logic ld_err, ld_visit;

	assign n_act = (num_q > NumW'(MaxVertices)) ? NumW'(MaxVertices) : num_q;

	// config register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_q <= NumW'(MaxVertices);
		else if (cfg.valid) num_q <= cfg.data;
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign a_ok      = ({1'b0, req.data.first_vertex} < n_act);
	assign b_ok      = ({1'b0, req.data.second_vertex} < n_act);

	gbdt_worklist u_wl (.clk, .arst_n, .ctrl(wl), .stat(ws));
	gbdt_edges u_edges (
		.clk, .arst_n, .add, .add_src(a_q), .add_dst(b_q),
		.head_rd, .head_vtx(ws.rd_vtx), .edge_rd, .edge_addr(e_q[EdgeW-1:0]),
		.full, .head_q, .tgt_q, .link_q
	);

	assign edge_ok = ({1'b0, tgt_q} < n_act) && !vis_q[tgt_q] && !ws.full;

	// sequencer
	always_comb begin
		state_d  = state_q;
		wl       = '0;
		wl.lifo  = dfs_q;
		add      = 1'b0;
		head_rd  = 1'b0;
		edge_rd  = 1'b0;
		ld_err   = 1'b0;
		ld_visit = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.data.action)
						ACT_ADD: state_d = (a_ok && b_ok && !full) ? S_ADD : S_ERR;
						ACT_DFS, ACT_BFS: begin
							if (a_ok) begin
								wl.clear = 1'b1;
								state_d  = S_START;
							end else state_d = S_ERR;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				add     = 1'b1;
				state_d = S_IDLE;
			end
			S_ERR: begin
				if (!out_v_q) begin
					ld_err  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_START: begin
				wl.push     = 1'b1;
				wl.push_vtx = a_q;
				state_d     = S_POP;
			end
			S_POP: begin
				// held visit goes out here; empty list makes it the last
				if (!have_q || !out_v_q) begin
					ld_visit = have_q;
					if (ws.empty) state_d = S_IDLE;
					else begin
						wl.pop  = 1'b1;
						state_d = S_POPRD;
					end
				end
			end
			S_POPRD: begin
				head_rd = 1'b1;
				state_d = S_HEADRD;
			end
			S_HEADRD: state_d = S_HEAD;
			S_HEAD: begin
				if (e_q[EdgeW] || steps_q[EdgeW]) state_d = S_POP;
				else begin
					edge_rd = 1'b1;
					state_d = S_EDGE;
				end
			end
			S_EDGE: begin
				if (edge_ok) begin
					wl.push     = 1'b1;
					wl.push_vtx = tgt_q;
				end
				state_d = S_HEAD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// request capture, edge pointer, visited map
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q   <= req.data.first_vertex;
			b_q   <= req.data.second_vertex;
			dfs_q <= (req.data.action == ACT_DFS);
			err_q <= (a_ok && b_ok) ? ST_FULL : ST_RANGE;
		end
		if (wl.clear) vis_q <= '0;
		else if (wl.push) vis_q[wl.push_vtx] <= 1'b1;
		if (state_q == S_POPRD) cur_q <= ws.rd_vtx;
		if (state_q == S_HEADRD) begin
			e_q     <= head_q;
			steps_q <= '0;
		end else if (state_q == S_EDGE) begin
			e_q     <= link_q;
			steps_q <= steps_q + (EdgeW+1)'(1);
		end
	end

	// a popped vertex is held until its list is walked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) have_q <= 1'b0;
		else if (state_q == S_POPRD) have_q <= 1'b1;
		else if (ld_visit) have_q <= 1'b0;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (ld_err || ld_visit) out_v_q <= 1'b1;
		else if (res.valid && res.ready) out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ld_err) out_q <= '{vertex: '0, status: err_q, last: 1'b1};
		else if (ld_visit) out_q <= '{vertex: cur_q, status: ST_VISIT, last: ws.empty};
	end

	assign res.valid = out_v_q;
	assign res.data  = out_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.data))
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		add |-> !full) else $error("append into full store");
	assert property (@(posedge clk) disable iff (!arst_n)
		wl.push |-> !ws.full) else $error("work list overflow");
`endif
endmodule
`default_nettype wire

// File: rtl/core/gbdt_worklist.sv
`default_nettype none
// Queue/stack of vertices; pop data is registered, valid in the cycle after the pop request.
module gbdt_worklist (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gbdt_pkg::wl_ctrl_t ctrl,
	output gbdt_pkg::wl_stat_t      stat
);
	import gbdt_pkg::*;

	logic [VtxW-1:0] store [MaxVertices];
	logic [CntW-1:0] front_q, back_q;
	logic [VtxW-1:0] rd_q;
	logic [CntW-1:0] back_m1;

	assign back_m1 = back_q - CntW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
		end else if (ctrl.clear) begin
			front_q <= '0;
			back_q  <= '0;
		end else if (ctrl.push) begin
			back_q <= back_q + CntW'(1);
		end else if (ctrl.pop) begin
			if (ctrl.lifo) back_q <= back_m1;
			else front_q <= front_q + CntW'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (ctrl.push && !ctrl.clear) store[back_q[VtxW-1:0]] <= ctrl.push_vtx;
		if (ctrl.pop) rd_q <= ctrl.lifo ? store[back_m1[VtxW-1:0]]
			: store[front_q[VtxW-1:0]];
	end

	assign stat.empty  = (back_q == front_q);
	assign stat.full   = (back_q == CntW'(MaxVertices));
	assign stat.rd_vtx = rd_q;
endmodule
`default_nettype wire

// File: rtl/core/gbdt_edges.sv
`default_nettype none
// Adjacency store: list heads with valid bits, tails, edge target/link memory.
// An append writes the new entry first and links an old tail in the cycle after.
module gbdt_edges (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      add,
	input  wire logic [gbdt_pkg::VtxW-1:0] add_src,
	input  wire logic [gbdt_pkg::VtxW-1:0] add_dst,
	input  wire logic                      head_rd,
	input  wire logic [gbdt_pkg::VtxW-1:0] head_vtx,
	input  wire logic                      edge_rd,
	input  wire logic [gbdt_pkg::EdgeW-1:0] edge_addr,
	output logic                           full,
	output logic [gbdt_pkg::LinkW-1:0]     head_q,
	output logic [gbdt_pkg::VtxW-1:0]      tgt_q,
	output logic [gbdt_pkg::LinkW-1:0]     link_q
);
	import gbdt_pkg::*;

	localparam int EcW = $clog2(MaxEdges + 1);

	logic [MaxVertices-1:0] hvalid_q;
	logic [EdgeW-1:0]       head_mem [MaxVertices];
	logic [EdgeW-1:0]       tail_mem [MaxVertices];
	logic [VtxW-1:0]        tgt_mem  [MaxEdges];
	logic [LinkW-1:0]       link_mem [MaxEdges];
	logic [EcW-1:0]         count_q;
	logic [EdgeW-1:0]       new_e;
	logic                   lnk_pend_q;
	logic [EdgeW-1:0]       lnk_addr_q;
	logic [EdgeW-1:0]       lnk_val_q;

	assign full  = (count_q == EcW'(MaxEdges));
	assign new_e = count_q[EdgeW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q   <= '0;
			count_q    <= '0;
			lnk_pend_q <= 1'b0;
		end else begin
			lnk_pend_q <= add && hvalid_q[add_src];
			if (add) begin
				hvalid_q[add_src] <= 1'b1;
				count_q <= count_q + EcW'(1);
			end
		end
	end

	// append: new edge now, link from old tail next cycle
	always_ff @(posedge clk) begin
		if (add) begin
			tgt_mem[new_e]    <= add_dst;
			tail_mem[add_src] <= new_e;
			lnk_addr_q        <= tail_mem[add_src];
			lnk_val_q         <= new_e;
			if (!hvalid_q[add_src]) head_mem[add_src] <= new_e;
		end
		if (add) link_mem[new_e] <= NullLink;
		else if (lnk_pend_q) link_mem[lnk_addr_q] <= LinkW'(lnk_val_q);
	end

	// reads
	always_ff @(posedge clk) begin
		if (head_rd) head_q <= hvalid_q[head_vtx] ? LinkW'(head_mem[head_vtx]) : NullLink;
		if (edge_rd) begin
			tgt_q  <= tgt_mem[edge_addr];
			link_q <= link_mem[edge_addr];
		end
	end
endmodule
`default_nettype wire

// File: tb/gbdt_tb_checker.sv
`timescale 1ns / 100ps
module gbdt_tb_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	gbdt_req_if.sink  req_mon,
	gbdt_res_if.sink  res_mon,
	gbdt_cfg_if.sink  cfg_mon,
	output int        fail_count,
	output int        pending
);
	import gbdt_pkg::*;

	// shadow graph state
	logic [5:0]       vtx_count;
	logic [LinkW-1:0] head_ptr [MaxVertices];
	logic [LinkW-1:0] tail_ptr [MaxVertices];
	logic [VtxW-1:0]  dest_of [MaxEdges];
	logic [LinkW-1:0] next_of [MaxEdges];
	int               stored_edges;
	res_t             visit_queue [$];

	function automatic int limit_count();
		return (vtx_count > MaxVertices) ? MaxVertices : int'(vtx_count);
	endfunction

	function automatic void push_one(logic [1:0] st);
		res_t r;
		r.vertex = '0;
		r.status = st;
		r.last   = 1'b1;
		visit_queue.push_back(r);
	endfunction

	// expected results of one request; updates the shadow store
	function automatic void predict_request(req_t rq);
		int n;
		int e;
		int steps;
		int cur;
		int t;
		int front;
		int back;
		int emitted;
		bit seen [MaxVertices];
		logic [VtxW-1:0] work [MaxVertices];
		res_t r;
		n = limit_count();
		case (action_t'(rq.action))
			ACT_ADD: begin
				if (rq.first_vertex >= n || rq.second_vertex >= n) begin
					push_one(ST_RANGE);
				end else if (stored_edges >= MaxEdges) begin
					push_one(ST_FULL);
				end else begin
					e = stored_edges;
					dest_of[e] = rq.second_vertex;
					next_of[e] = NullLink;
					if (head_ptr[rq.first_vertex] == NullLink)
						head_ptr[rq.first_vertex] = LinkW'(e);
					else
						next_of[tail_ptr[rq.first_vertex]] = LinkW'(e);
					tail_ptr[rq.first_vertex] = LinkW'(e);
					stored_edges++;
				end
			end
			ACT_DFS, ACT_BFS: begin
				if (rq.first_vertex >= n) begin
					push_one(ST_RANGE);
				end else begin
					foreach (seen[i]) seen[i] = 0;
					front = 0;
					back = 0;
					emitted = 0;
					work[back++] = rq.first_vertex;
					seen[rq.first_vertex] = 1;
					while (back > front) begin
						if (rq.action == ACT_DFS) begin
							back--;
							cur = work[back];
						end else begin
							cur = work[front];
							front++;
						end
						r.vertex = VtxW'(cur);
						r.status = ST_VISIT;
						r.last   = 1'b0;
						visit_queue.push_back(r);
						emitted++;
						e = head_ptr[cur];
						steps = 0;
						while (e < MaxEdges && steps < MaxEdges) begin
							t = dest_of[e];
							if (t < n && !seen[t] && back < MaxVertices) begin
								seen[t] = 1;
								work[back++] = VtxW'(t);
							end
							e = next_of[e];
							steps++;
						end
					end
					if (emitted > 0) begin
						r = visit_queue[$];
						r.last = 1'b1;
						visit_queue[$] = r;
					end
				end
			end
			default: ;
		endcase
	endfunction

	assign pending = visit_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_count <= 6'd32;
			for (int i = 0; i < MaxVertices; i++) begin
				head_ptr[i] = NullLink;
				tail_ptr[i] = '0;
			end
			stored_edges = 0;
			fail_count <= 0;
			visit_queue.delete();
		end else begin
			if (cfg_mon.valid && cfg_mon.ready)
				vtx_count <= cfg_mon.data;
			if (req_mon.valid && req_mon.ready)
				predict_request(req_mon.data);
			// compare each accepted result with the oldest expectation
			if (res_mon.valid && res_mon.ready) begin
				if (visit_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result v=%0d st=%0d last=%0d",
							res_mon.data.vertex, res_mon.data.status, res_mon.data.last);
					fail_count <= fail_count + 1;
				end else begin
					if (res_mon.data !== visit_queue[0]) begin
						if (fail_count < 10)
							$display("mismatch exp v=%0d st=%0d last=%0d got v=%0d st=%0d last=%0d",
								visit_queue[0].vertex, visit_queue[0].status, visit_queue[0].last,
								res_mon.data.vertex, res_mon.data.status, res_mon.data.last);
						fail_count <= fail_count + 1;
					end
					void'(visit_queue.pop_front());
				end
			end
		end
	end
endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
module tb;
	import gbdt_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;

	gbdt_req_if req_ch ();
	gbdt_res_if res_ch ();
	gbdt_cfg_if cfg_ch ();

	graph_bfs_dfs_traversal uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.res    (res_ch.source),
		.cfg    (cfg_ch.sink)
	);

	gbdt_tb_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_mon    (req_ch.sink),
		.res_mon    (res_ch.sink),
		.cfg_mon    (cfg_ch.sink),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// send one request, with a random gap first
	task automatic send_request(action_t act, int a, int b);
		repeat ($urandom_range(0, 11)) @(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data  <= '{action: act, first_vertex: VtxW'(a), second_vertex: VtxW'(b)};
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		req_ch.valid <= 1'b0;
		req_ch.data  <= '{action: 2'($urandom_range(0, 3)), first_vertex: VtxW'($urandom),
			second_vertex: VtxW'($urandom)};
	endtask

	// wait until idle, then write the vertex count
	task automatic write_count(int value);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= NumW'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic random_phase(int items, int n);
		int hi;
		hi = (n < 1) ? 31 : n - 1;
		repeat (items) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					send_request(ACT_ADD, $urandom_range(0, hi), $urandom_range(0, hi));
				end
				5, 6: send_request(ACT_DFS, $urandom_range(0, hi), $urandom);
				7, 8: send_request(ACT_BFS, $urandom_range(0, hi), $urandom);
				default: send_request(action_t'($urandom_range(0, 3)), $urandom, $urandom);
			endcase
		end
	endtask

	// result side: ready held low for a random gap before each result
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, 11);
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			@(negedge clk);
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extremes, all actions, error cases
		send_request(ACT_DFS, 0, 0);
		send_request(ACT_ADD, 0, 31);
		send_request(ACT_ADD, 31, 0);
		send_request(ACT_ADD, 0, 1);
		send_request(ACT_ADD, 1, 2);
		send_request(ACT_ADD, 0, 2);
		send_request(ACT_ADD, 2, 0);
		send_request(ACT_DFS, 0, 0);
		send_request(ACT_BFS, 0, 31);
		send_request(ACT_BFS, 31, 0);
		send_request(ACT_NONE, 31, 31);
		write_count(2);
		send_request(ACT_ADD, 2, 0);
		send_request(ACT_ADD, 0, 5);
		send_request(ACT_DFS, 0, 0);
		send_request(ACT_BFS, 1, 0);
		send_request(ACT_BFS, 3, 0);
		write_count(0);
		send_request(ACT_ADD, 0, 0);
		send_request(ACT_DFS, 0, 0);
		write_count(63);
		send_request(ACT_BFS, 2, 0);
		write_count(1);
		send_request(ACT_ADD, 0, 0);
		send_request(ACT_DFS, 0, 0);

		// random phases over several vertex counts
		write_count(32);
		random_phase(30, 32);
		write_count(8);
		random_phase(20, 8);
		write_count(20);
		random_phase(20, 20);
		write_count(32);
		random_phase(6, 32);

		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
